@@ design/dsf_pkg.sv @@
// dsf_pkg: shared types, symbol codes and the CRC-16 step for the dibit symbol framer.
// Depends on nothing; used by dsf_front, dsf_queue, dsf_back and dibit_symbol_framer_crc16.
package dsf_pkg;

    localparam int SYM_W = 3;

    localparam logic [SYM_W-1:0] SYM_BIT_SEP  = 3'd4;
    localparam logic [SYM_W-1:0] SYM_BYTE_SEP = 3'd5;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Job queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW    = $clog2(QDEPTH + 1);

    // One queued request: message byte plus what the back needs to frame it
    typedef struct packed {
        logic [7:0]  data;
        logic [15:0] crc;       // CRC including this byte
        logic        preamble;  // first byte of a frame
        logic        last;      // final byte, append CRC and tail
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } q_push_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } q_head_t;

    // Reflected CRC-16, one byte
    function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                 input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ design/dsf_front.sv @@
// dsf_front: accepts message bytes, tracks frame start and the running CRC,
// and pushes one job per byte into the queue. Depends on dsf_pkg.
module dsf_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       data_byte,
    input  logic             is_last,
    input  logic             byte_valid,
    output logic             byte_stall,
    input  logic             q_full,
    output dsf_pkg::q_push_t push
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        frame_start_reg;
    logic        frame_start_next;
    logic [15:0] crc_upd;
    logic        take;

    assign byte_stall = q_full;
    assign take       = byte_valid && !q_full;
    assign crc_upd    = dsf_pkg::crc16_update(crc_reg, data_byte);

    always_comb
    begin
        crc_next         = crc_reg;
        frame_start_next = frame_start_reg;
        if (take)
        begin
            // frame ends on the last byte: back to reset values
            crc_next         = is_last ? dsf_pkg::CRC_INIT : crc_upd;
            frame_start_next = is_last;
        end
    end

    always_comb
    begin
        push.valid        = take;
        push.job.data     = data_byte;
        push.job.crc      = crc_upd;
        push.job.preamble = frame_start_reg;
        push.job.last     = is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg         <= dsf_pkg::CRC_INIT;
            frame_start_reg <= 1'b1;
        end
        else
        begin
            crc_reg         <= crc_next;
            frame_start_reg <= frame_start_next;
        end
    end

endmodule

@@ design/dsf_queue.sv @@
// dsf_queue: short FIFO of framing jobs between front and back.
// Depends on dsf_pkg.
module dsf_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  dsf_pkg::q_push_t push,
    output logic             full,
    input  logic             pop,
    output dsf_pkg::q_head_t head
);

    dsf_pkg::job_t mem [dsf_pkg::QDEPTH];

    logic [dsf_pkg::QPW-1:0] wr_ptr_reg;
    logic [dsf_pkg::QPW-1:0] wr_ptr_next;
    logic [dsf_pkg::QPW-1:0] rd_ptr_reg;
    logic [dsf_pkg::QPW-1:0] rd_ptr_next;
    logic [dsf_pkg::QCW-1:0] count_reg;
    logic [dsf_pkg::QCW-1:0] count_next;
    logic                    do_push;
    logic                    do_pop;

    assign full       = (count_reg == dsf_pkg::QCW'(dsf_pkg::QDEPTH));
    assign head.valid = (count_reg != '0);
    assign head.job   = mem[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == dsf_pkg::QPW'(dsf_pkg::QDEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == dsf_pkg::QPW'(dsf_pkg::QDEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ design/dsf_back.sv @@
// dsf_back: symbol sequencer. Expands a job into preamble (frame start),
// byte framing, CRC framing and tail (last byte), one symbol per cycle
// into an output register while symbol_stall is low. Depends on dsf_pkg.
module dsf_back
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  dsf_pkg::q_head_t          head,
    output logic                      pop,
    output logic [dsf_pkg::SYM_W-1:0] symbol,
    output logic                      last_symbol,
    output logic                      symbol_valid,
    input  logic                      symbol_stall
);

    localparam logic [2:0] PH_PRE0 = 3'd0;
    localparam logic [2:0] PH_PRE1 = 3'd1;
    localparam logic [2:0] PH_BSEP = 3'd2;
    localparam logic [2:0] PH_DIB  = 3'd3;
    localparam logic [2:0] PH_TAL0 = 3'd4;
    localparam logic [2:0] PH_TAL1 = 3'd5;

    // byte select within a job
    localparam logic [1:0] SEL_MSG    = 2'd0;
    localparam logic [1:0] SEL_CRC_LO = 2'd1;
    localparam logic [1:0] SEL_CRC_HI = 2'd2;

    dsf_pkg::job_t               job_reg;
    dsf_pkg::job_t               job_next;
    logic                        job_valid_reg;
    logic                        job_valid_next;
    logic [2:0]                  phase_reg;
    logic [2:0]                  phase_next;
    logic [1:0]                  sel_reg;
    logic [1:0]                  sel_next;
    logic [1:0]                  k_reg;
    logic [1:0]                  k_next;
    logic [dsf_pkg::SYM_W-1:0]   prev_reg;
    logic [dsf_pkg::SYM_W-1:0]   prev_next;
    logic [dsf_pkg::SYM_W-1:0]   sym_reg;
    logic [dsf_pkg::SYM_W-1:0]   sym_next;
    logic                        last_reg;
    logic                        last_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;

    logic [7:0]                  cur_byte;
    logic [1:0]                  dibit;
    logic [dsf_pkg::SYM_W-1:0]   emit_sym;
    logic                        emit_last;
    logic                        done;
    logic                        emit;
    logic                        load;
    logic [2:0]                  ph_after;
    logic [1:0]                  sel_after;
    logic [1:0]                  k_after;

    assign emit = job_valid_reg && (!out_valid_reg || !symbol_stall);
    assign load = head.valid && (!job_valid_reg || (emit && done));
    assign pop  = load;

    always_comb
    begin
        case (sel_reg)
            SEL_MSG:    cur_byte = job_reg.data;
            SEL_CRC_LO: cur_byte = job_reg.crc[7:0];
            SEL_CRC_HI: cur_byte = job_reg.crc[15:8];
            default:    cur_byte = job_reg.data;
        endcase
    end

    // dibit k, most significant first
    assign dibit = 2'(cur_byte >> {~k_reg, 1'b0});

    always_comb
    begin
        emit_sym  = dsf_pkg::SYM_BYTE_SEP;
        emit_last = 1'b0;
        done      = 1'b0;
        ph_after  = phase_reg;
        sel_after = sel_reg;
        k_after   = k_reg;
        case (phase_reg)
            PH_PRE0:
            begin
                ph_after = PH_PRE1;
            end
            PH_PRE1:
            begin
                ph_after = PH_BSEP;
            end
            PH_BSEP:
            begin
                ph_after = PH_DIB;
                k_after  = 2'd0;
            end
            PH_DIB:
            begin
                if ({1'b0, dibit} == prev_reg)
                begin
                    emit_sym = dsf_pkg::SYM_BIT_SEP;
                end
                else
                begin
                    emit_sym = {1'b0, dibit};
                    k_after  = k_reg + 1'b1;
                    if (k_reg == 2'd3)
                    begin
                        if (sel_reg == SEL_CRC_HI)
                        begin
                            ph_after = PH_TAL0;
                        end
                        else if (sel_reg == SEL_MSG && !job_reg.last)
                        begin
                            done = 1'b1;
                        end
                        else
                        begin
                            sel_after = sel_reg + 1'b1;
                            ph_after  = PH_BSEP;
                        end
                    end
                end
            end
            PH_TAL0:
            begin
                emit_sym = prev_reg;
                ph_after = PH_TAL1;
            end
            PH_TAL1:
            begin
                emit_sym  = prev_reg;
                emit_last = 1'b1;
                done      = 1'b1;
            end
            default:
            begin
                done = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        job_next       = job_reg;
        job_valid_next = job_valid_reg;
        phase_next     = phase_reg;
        sel_next       = sel_reg;
        k_next         = k_reg;
        prev_next      = prev_reg;
        sym_next       = sym_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;

        if (emit)
        begin
            sym_next       = emit_sym;
            last_next      = emit_last;
            out_valid_next = 1'b1;
            phase_next     = ph_after;
            sel_next       = sel_after;
            k_next         = k_after;
            // frame end restores the separator as previous symbol
            prev_next      = emit_last ? dsf_pkg::SYM_BYTE_SEP : emit_sym;
            if (done)
            begin
                job_valid_next = 1'b0;
            end
        end
        else if (!symbol_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (load)
        begin
            job_next       = head.job;
            job_valid_next = 1'b1;
            phase_next     = head.job.preamble ? PH_PRE0 : PH_BSEP;
            sel_next       = SEL_MSG;
            k_next         = 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        sym_reg <= sym_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            phase_reg     <= PH_BSEP;
            sel_reg       <= SEL_MSG;
            k_reg         <= 2'd0;
            prev_reg      <= dsf_pkg::SYM_BYTE_SEP;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            phase_reg     <= phase_next;
            sel_reg       <= sel_next;
            k_reg         <= k_next;
            prev_reg      <= prev_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign symbol       = sym_reg;
    assign last_symbol  = last_reg;
    assign symbol_valid = out_valid_reg;

endmodule

@@ design/dibit_symbol_framer_crc16.sv @@
// dibit_symbol_framer_crc16: top level of the dibit symbol framer.
// Depends on dsf_pkg, dsf_front, dsf_queue and dsf_back.

// Frames message bytes into 3-bit acoustic modem symbols (0..3 dibit, 4 bit
// separator, 5 byte separator) and appends a reflected CRC-16 (poly 0xA001,
// init 0xFFFF). A frame opens with two byte separators; each byte is a byte
// separator plus four dibits MSB first, with a bit separator before any dibit
// equal to the symbol just sent. The byte flagged is_last is followed by the
// CRC, low byte first, and by the final symbol sent twice more, the second
// time with last_symbol high. Symbols leave one per cycle from the output
// register while symbol_stall is low, so the symbol sequencer sets the
// sustained byte rate; it holds one byte request at a time and takes a new
// one from the queue as it sends the final symbol of the current one. A
// two-entry job queue sits between byte intake and the sequencer, so new
// bytes are taken while symbols are still going out and byte_stall rises
// only when the queue is full. A byte accepted while the sequencer is idle
// passes the queue, job register and output register before its first symbol.
module dibit_symbol_framer_crc16
(
    input  logic                      clk,
    input  logic                      rst_n,
    // byte request channel
    input  logic [7:0]                data_byte,
    input  logic                      is_last,
    input  logic                      byte_valid,
    output logic                      byte_stall,
    // symbol request channel
    output logic [dsf_pkg::SYM_W-1:0] symbol,
    output logic                      last_symbol,
    output logic                      symbol_valid,
    input  logic                      symbol_stall
);

    dsf_pkg::q_push_t q_push;
    dsf_pkg::q_head_t q_head;
    logic             q_full;
    logic             q_pop;

    // intake: frame start flag and running CRC
    dsf_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_byte  (data_byte),
        .is_last    (is_last),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .q_full     (q_full),
        .push       (q_push)
    );

    // decouples intake from symbol output
    dsf_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .full  (q_full),
        .pop   (q_pop),
        .head  (q_head)
    );

    // symbol sequencer and output register
    dsf_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .pop          (q_pop),
        .symbol       (symbol),
        .last_symbol  (last_symbol),
        .symbol_valid (symbol_valid),
        .symbol_stall (symbol_stall)
    );

    // only defined symbol codes leave the block
    a_sym_range: assert property (@(posedge clk) disable iff (!rst_n)
        symbol_valid |-> (symbol <= dsf_pkg::SYM_BYTE_SEP))
        else $error("symbol code out of range");

    // tail repeats the last CRC dibit, never a separator
    a_tail_dibit: assert property (@(posedge clk) disable iff (!rst_n)
        (symbol_valid && last_symbol) |-> (symbol < dsf_pkg::SYM_BIT_SEP))
        else $error("frame tail is not a dibit");

    // intake stalls only while the queue holds work for the sequencer
    a_stall_work: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> q_head.valid)
        else $error("byte stall with empty job queue");

    // a frame end symbol is followed by a byte separator or idle, never a
    // bit separator
    a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (symbol_valid && !symbol_stall && last_symbol) |=>
        (!symbol_valid || (symbol != dsf_pkg::SYM_BIT_SEP)))
        else $error("bit separator right after frame end");

endmodule
